// File: rtl/sgi_pkg.sv
// ----------------------------------------------------------------------------
// sgi_pkg: shared constants for the segment intersection block
// Default coordinate width used by the top level and its submodules.
// ----------------------------------------------------------------------------
package sgi_pkg;

  localparam int unsigned CoordBitsDef = 16;

endpackage

// File: rtl/sgi_front.sv
// ----------------------------------------------------------------------------
// sgi_front: differences, cross products, hit test and numerator product
// Five register stages; all advance together on en_i.
// ----------------------------------------------------------------------------
module sgi_front #(
  parameter int unsigned CW = sgi_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [CW-1:0]        px_i,
  input  logic signed [CW-1:0]        py_i,
  input  logic signed [CW-1:0]        ex_i,
  input  logic signed [CW-1:0]        ey_i,
  input  logic signed [CW-1:0]        qx_i,
  input  logic signed [CW-1:0]        qy_i,
  input  logic signed [CW-1:0]        fx_i,
  input  logic signed [CW-1:0]        fy_i,
  output logic                        valid_o,
  output logic                        hit_o,
  output logic signed [CW-1:0]        base_x_o,
  output logic signed [CW-1:0]        base_y_o,
  output logic                        neg_x_o,
  output logic                        neg_y_o,
  output logic [3*CW+1:0]             num_x_o,
  output logic [3*CW+1:0]             num_y_o,
  output logic [2*CW+1:0]             den_o
);

  localparam int unsigned RW = CW + 1;
  localparam int unsigned PW = 2 * RW;
  localparam int unsigned XW = 2 * CW + 3;
  localparam int unsigned MW = 2 * CW + 2;
  localparam int unsigned NW = 3 * CW + 2;

  // stage 1: differences
  logic                 v1_q;
  logic signed [RW-1:0] rx1_q, ry1_q, sx1_q, sy1_q, wx1_q, wy1_q;
  logic signed [CW-1:0] px1_q, py1_q, ex1_q, ey1_q;
  logic                 eqs1_q, eqe1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx1_q  <= RW'(ex_i) - RW'(px_i);
      ry1_q  <= RW'(ey_i) - RW'(py_i);
      sx1_q  <= RW'(fx_i) - RW'(qx_i);
      sy1_q  <= RW'(fy_i) - RW'(qy_i);
      wx1_q  <= RW'(qx_i) - RW'(px_i);
      wy1_q  <= RW'(qy_i) - RW'(py_i);
      px1_q  <= px_i;
      py1_q  <= py_i;
      ex1_q  <= ex_i;
      ey1_q  <= ey_i;
      eqs1_q <= (px_i == fx_i) && (py_i == fy_i);
      eqe1_q <= (ex_i == qx_i) && (ey_i == qy_i);
    end
  end

  // stage 2: six products
  logic                 v2_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [RW-1:0] rx2_q, ry2_q;
  logic signed [CW-1:0] px2_q, py2_q, ex2_q, ey2_q;
  logic                 eqs2_q, eqe2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q   <= PW'(rx1_q) * PW'(sy1_q);
      p1_q   <= PW'(ry1_q) * PW'(sx1_q);
      p2_q   <= PW'(wx1_q) * PW'(sy1_q);
      p3_q   <= PW'(wy1_q) * PW'(sx1_q);
      p4_q   <= PW'(wx1_q) * PW'(ry1_q);
      p5_q   <= PW'(wy1_q) * PW'(rx1_q);
      rx2_q  <= rx1_q;
      ry2_q  <= ry1_q;
      px2_q  <= px1_q;
      py2_q  <= py1_q;
      ex2_q  <= ex1_q;
      ey2_q  <= ey1_q;
      eqs2_q <= eqs1_q;
      eqe2_q <= eqe1_q;
    end
  end

  // stage 3: cross products
  logic                 v3_q;
  logic signed [XW-1:0] d3_q, tn3_q, un3_q;
  logic signed [RW-1:0] rx3_q, ry3_q;
  logic signed [CW-1:0] px3_q, py3_q, ex3_q, ey3_q;
  logic                 eqs3_q, eqe3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d3_q   <= XW'(p0_q) - XW'(p1_q);
      tn3_q  <= XW'(p2_q) - XW'(p3_q);
      un3_q  <= XW'(p4_q) - XW'(p5_q);
      rx3_q  <= rx2_q;
      ry3_q  <= ry2_q;
      px3_q  <= px2_q;
      py3_q  <= py2_q;
      ex3_q  <= ex2_q;
      ey3_q  <= ey2_q;
      eqs3_q <= eqs2_q;
      eqe3_q <= eqe2_q;
    end
  end

  // stage 4: sign normalize, range test, operand select
  logic signed [XW-1:0] dn_d, tnn_d, unn_d;
  logic                 hit_cr_d, col_d;
  logic signed [RW-1:0] arx_d, ary_d;

  always_comb begin
    dn_d     = d3_q[XW-1] ? -d3_q  : d3_q;
    tnn_d    = d3_q[XW-1] ? -tn3_q : tn3_q;
    unn_d    = d3_q[XW-1] ? -un3_q : un3_q;
    hit_cr_d = (d3_q != '0) && !tnn_d[XW-1] && (tnn_d <= dn_d)
               && !unn_d[XW-1] && (unn_d <= dn_d);
    col_d    = (d3_q == '0) && (un3_q == '0) && (eqs3_q || eqe3_q);
    arx_d    = rx3_q[RW-1] ? -rx3_q : rx3_q;
    ary_d    = ry3_q[RW-1] ? -ry3_q : ry3_q;
  end

  logic              v4_q, hit4_q, nx4_q, ny4_q;
  logic signed [CW-1:0] bx4_q, by4_q;
  logic [CW-1:0]     mx4_q, my4_q;
  logic [MW-1:0]     tn4_q, d4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit4_q <= hit_cr_d || col_d;
      // collinear touch at a_end only when a_start does not match b_end
      bx4_q  <= (col_d && !eqs3_q) ? ex3_q : px3_q;
      by4_q  <= (col_d && !eqs3_q) ? ey3_q : py3_q;
      nx4_q  <= rx3_q[RW-1];
      ny4_q  <= ry3_q[RW-1];
      mx4_q  <= arx_d[CW-1:0];
      my4_q  <= ary_d[CW-1:0];
      tn4_q  <= hit_cr_d ? tnn_d[MW-1:0] : '0;
      d4_q   <= hit_cr_d ? dn_d[MW-1:0] : MW'(1);
    end
  end

  // stage 5: numerator |r| * tn
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o    <= hit4_q;
      base_x_o <= bx4_q;
      base_y_o <= by4_q;
      neg_x_o  <= nx4_q;
      neg_y_o  <= ny4_q;
      num_x_o  <= NW'(mx4_q) * NW'(tn4_q);
      num_y_o  <= NW'(my4_q) * NW'(tn4_q);
      den_o    <= d4_q;
    end
  end

endmodule

// File: rtl/sgi_div.sv
// ----------------------------------------------------------------------------
// sgi_div: pipelined restoring divider, one quotient bit per stage
// Quotient is known to fit in CW bits; CW stages.
// ----------------------------------------------------------------------------
module sgi_div #(
  parameter int unsigned CW = sgi_pkg::CoordBitsDef
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [3*CW+1:0]   num_i,
  input  logic [2*CW+1:0]   den_i,
  output logic [CW-1:0]     quo_o
);

  localparam int unsigned MW = 2 * CW + 2;
  localparam int unsigned NW = 3 * CW + 2;

  logic [NW-1:0] rem_q [CW];
  logic [MW-1:0] den_q [CW];
  logic [CW-1:0] quo_q [CW];

  for (genvar k = 0; k < CW; k++) begin : g_stage
    logic [NW-1:0] rem_in, sub;
    logic [MW-1:0] den_in;
    logic [CW-1:0] quo_in;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign sub  = NW'(den_in) << (CW - 1 - k);
    assign take = (rem_in >= sub);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? rem_in - sub : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[CW-2:0], take};
      end
    end
  end

  assign quo_o = quo_q[CW-1];

endmodule

// File: rtl/segment_intersection_int.sv
// ----------------------------------------------------------------------------
// segment_intersection_int: integer segment intersection, cross-product test
// One pair per cycle sustained while the output register is empty or being
// taken; the whole pipeline advances together under that condition. Reset
// (rst_ni low, asynchronous) clears all valid bits; payload registers are
// not reset.
// ----------------------------------------------------------------------------
module segment_intersection_int #(
  parameter int unsigned COORD_BITS = sgi_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [COORD_BITS-1:0]  a_start_x_i,
  input  logic signed [COORD_BITS-1:0]  a_start_y_i,
  input  logic signed [COORD_BITS-1:0]  a_end_x_i,
  input  logic signed [COORD_BITS-1:0]  a_end_y_i,
  input  logic signed [COORD_BITS-1:0]  b_start_x_i,
  input  logic signed [COORD_BITS-1:0]  b_start_y_i,
  input  logic signed [COORD_BITS-1:0]  b_end_x_i,
  input  logic signed [COORD_BITS-1:0]  b_end_y_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic                          hit_o,
  output logic signed [COORD_BITS:0]    point_x_o,
  output logic signed [COORD_BITS:0]    point_y_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned MW = 2 * CW + 2;
  localparam int unsigned NW = 3 * CW + 2;

  // Global advance: stages move when the output slot is free or its
  // transfer happens this cycle.
  logic en;
  assign en      = !valid_o || ready_i;
  assign ready_o = en;

  // Front end: diffs, cross products, range test, numerator (5 stages).
  logic                 f_valid, f_hit, f_nx, f_ny;
  logic signed [CW-1:0] f_bx, f_by;
  logic [NW-1:0]        f_numx, f_numy;
  logic [MW-1:0]        f_den;

  sgi_front #(.CW(CW)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (valid_i),
    .px_i     (a_start_x_i),
    .py_i     (a_start_y_i),
    .ex_i     (a_end_x_i),
    .ey_i     (a_end_y_i),
    .qx_i     (b_start_x_i),
    .qy_i     (b_start_y_i),
    .fx_i     (b_end_x_i),
    .fy_i     (b_end_y_i),
    .valid_o  (f_valid),
    .hit_o    (f_hit),
    .base_x_o (f_bx),
    .base_y_o (f_by),
    .neg_x_o  (f_nx),
    .neg_y_o  (f_ny),
    .num_x_o  (f_numx),
    .num_y_o  (f_numy),
    .den_o    (f_den)
  );

  // Two dividers share the denominator: trunc(|r| * t) per axis.
  logic [CW-1:0] qx, qy;

  sgi_div #(.CW(CW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (f_numx),
    .den_i (f_den),
    .quo_o (qx)
  );

  sgi_div #(.CW(CW)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (f_numy),
    .den_i (f_den),
    .quo_o (qy)
  );

  // Side band travels alongside the divider stages.
  logic                 dv_q  [CW];
  logic                 dh_q  [CW];
  logic                 dnx_q [CW];
  logic                 dny_q [CW];
  logic signed [CW-1:0] dbx_q [CW];
  logic signed [CW-1:0] dby_q [CW];

  for (genvar k = 0; k < CW; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= (k == 0) ? f_valid : dv_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (k == 0) begin
          dh_q[k]  <= f_hit;
          dnx_q[k] <= f_nx;
          dny_q[k] <= f_ny;
          dbx_q[k] <= f_bx;
          dby_q[k] <= f_by;
        end else begin
          dh_q[k]  <= dh_q[(k == 0) ? 0 : k-1];
          dnx_q[k] <= dnx_q[(k == 0) ? 0 : k-1];
          dny_q[k] <= dny_q[(k == 0) ? 0 : k-1];
          dbx_q[k] <= dbx_q[(k == 0) ? 0 : k-1];
          dby_q[k] <= dby_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // Final stage: restore sign of the offset, add the base, zero on miss.
  logic signed [CW:0] offx, offy, px_d, py_d;

  always_comb begin
    offx = dnx_q[CW-1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    offy = dny_q[CW-1] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    px_d = dh_q[CW-1] ? (CW+1)'(dbx_q[CW-1]) + offx : '0;
    py_d = dh_q[CW-1] ? (CW+1)'(dby_q[CW-1]) + offy : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= dv_q[CW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_o     <= dh_q[CW-1];
      point_x_o <= px_d;
      point_y_o <= py_d;
    end
  end

endmodule

// File: test/segment_intersection_checker.sv
// ----------------------------------------------------------------------------
// segment_intersection_checker: scoreboard for segment_intersection_int
// Watches both channels, predicts each result from the accepted segment pair
// and compares hit and meeting point against the oldest prediction.
// ----------------------------------------------------------------------------
module segment_intersection_checker #(
  parameter int unsigned COORD_BITS = sgi_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] a_start_x_i,
  input  logic signed [COORD_BITS-1:0] a_start_y_i,
  input  logic signed [COORD_BITS-1:0] a_end_x_i,
  input  logic signed [COORD_BITS-1:0] a_end_y_i,
  input  logic signed [COORD_BITS-1:0] b_start_x_i,
  input  logic signed [COORD_BITS-1:0] b_start_y_i,
  input  logic signed [COORD_BITS-1:0] b_end_x_i,
  input  logic signed [COORD_BITS-1:0] b_end_y_i,
  input  logic                         valid_o,
  input  logic                         ready_i,
  input  logic                         hit_o,
  input  logic signed [COORD_BITS:0]   point_x_o,
  input  logic signed [COORD_BITS:0]   point_y_o,
  output int                           errors_o,
  output int                           pending_o,
  output int                           hits_o,
  output int                           results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_BITS:0] px;
    logic signed [COORD_BITS:0] py;
  } crossing_t;

  crossing_t crossing_q[$];

  // Exact integer test; 64-bit math covers all products at 16-bit coords.
  function automatic crossing_t predict_crossing(
      longint ax, longint ay, longint ex, longint ey,
      longint qx, longint qy, longint fx, longint fy);
    longint rx, ry, sx, sy, wx, wy, d, tn, un, ox, oy;
    crossing_t c;
    rx = ex - ax; ry = ey - ay;
    sx = fx - qx; sy = fy - qy;
    wx = qx - ax; wy = qy - ay;
    d  = rx * sy - ry * sx;
    tn = wx * sy - wy * sx;
    un = wx * ry - wy * rx;
    c = '0;
    if (d == 0) begin
      // collinear: only end-to-start touching counts
      if (un == 0) begin
        if (ax == fx && ay == fy) begin
          c.hit = 1'b1; ox = ax; oy = ay;
          c.px = ox[COORD_BITS:0]; c.py = oy[COORD_BITS:0];
        end else if (ex == qx && ey == qy) begin
          c.hit = 1'b1; ox = ex; oy = ey;
          c.px = ox[COORD_BITS:0]; c.py = oy[COORD_BITS:0];
        end
      end
    end else begin
      if (d < 0) begin
        d = -d; tn = -tn; un = -un;
      end
      if (tn >= 0 && tn <= d && un >= 0 && un <= d) begin
        // SV division truncates toward zero; |r*tn| fits in 64 bits
        ox = ax + (rx * tn) / d;
        oy = ay + (ry * tn) / d;
        c.hit = 1'b1;
        c.px = ox[COORD_BITS:0]; c.py = oy[COORD_BITS:0];
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, results_o);
    errors_o++;
  endtask

  initial begin
    errors_o = 0; hits_o = 0; results_o = 0;
  end

  assign pending_o = crossing_q.size();

  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni && valid_i && ready_o)
      crossing_q.push_back(predict_crossing(a_start_x_i, a_start_y_i, a_end_x_i, a_end_y_i,
                                            b_start_x_i, b_start_y_i, b_end_x_i, b_end_y_i));
    if (rst_ni && valid_o && ready_i) begin
      if (crossing_q.size() == 0) begin
        $display("unexpected result transfer");
        errors_o++;
      end else begin
        want = crossing_q.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (point_x_o !== want.px) report_mismatch("point_x", point_x_o, want.px);
        if (point_y_o !== want.py) report_mismatch("point_y", point_y_o, want.py);
        if (want.hit) hits_o++;
      end
      results_o++;
    end
  end
endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for segment_intersection_int
// Directed corner pairs then random crossing, touching, collinear and noise
// pairs, with random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB = sgi_pkg::CoordBitsDef;
  localparam int LATENCY = CB + 6;
  localparam int N_RANDOM = 1430;
  localparam longint LIMIT = 200000;

  typedef logic signed [CB-1:0] coord_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic valid_in = 1'b0, ready_in, valid_out, ready_out = 1'b0;
  coord_t asx = '0, asy = '0, aex = '0, aey = '0;
  coord_t bsx = '0, bsy = '0, bex = '0, bey = '0;
  logic hit;
  logic signed [CB:0] px, py;
  int errors, pending, hits, results;
  longint cycles = 0;
  int items_sent = 0;
  bit stim_done = 0, calm = 0, hold_rx = 0;

  always #4 clk = ~clk;

  segment_intersection_int #(.COORD_BITS(CB)) u_dut (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(valid_in), .ready_o(ready_in),
    .a_start_x_i(asx), .a_start_y_i(asy), .a_end_x_i(aex), .a_end_y_i(aey),
    .b_start_x_i(bsx), .b_start_y_i(bsy), .b_end_x_i(bex), .b_end_y_i(bey),
    .valid_o(valid_out), .ready_i(ready_out), .hit_o(hit),
    .point_x_o(px), .point_y_o(py));

  segment_intersection_checker #(.COORD_BITS(CB)) u_chk (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(valid_in), .ready_o(ready_in),
    .a_start_x_i(asx), .a_start_y_i(asy), .a_end_x_i(aex), .a_end_y_i(aey),
    .b_start_x_i(bsx), .b_start_y_i(bsy), .b_end_x_i(bex), .b_end_y_i(bey),
    .valid_o(valid_out), .ready_i(ready_out), .hit_o(hit),
    .point_x_o(px), .point_y_o(py), .errors_o(errors), .pending_o(pending),
    .hits_o(hits), .results_o(results));

  // Offer one pair; holds valid until the transfer, optional idle burst first.
  task automatic send_pair(input coord_t ax, ay, ex, ey, qx, qy, fx, fy);
    if (!calm && $urandom_range(0, 3) == 0) begin
      valid_in <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    valid_in <= 1'b1;
    asx <= ax; asy <= ay; aex <= ex; aey <= ey;
    bsx <= qx; bsy <= qy; bex <= fx; bey <= fy;
    do @(posedge clk); while (!ready_in);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic coord_t rnd_coord(input int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  // Random pair biased toward the interesting shapes.
  task automatic send_random();
    coord_t ax, ay, ex, ey, qx, qy, fx, fy;
    int kind, span;
    span = ($urandom_range(0, 4) == 0) ? 0 : (1 << $urandom_range(2, 14));
    ax = rnd_coord(span); ay = rnd_coord(span);
    ex = rnd_coord(span); ey = rnd_coord(span);
    qx = rnd_coord(span); qy = rnd_coord(span);
    fx = rnd_coord(span); fy = rnd_coord(span);
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin // collinear, end touching start
        qx = ex; qy = ey; fx = ex + (ex - ax); fy = ey + (ey - ay);
      end
      1: begin // collinear, B ends at A start
        fx = ax; fy = ay; qx = ax - (ex - ax); qy = ay - (ey - ay);
      end
      2: begin // parallel shifted
        qx = coord_t'(ax + coord_t'(3)); qy = coord_t'(ay - coord_t'(5));
        fx = qx + (ex - ax); fy = qy + (ey - ay);
      end
      3: begin // degenerate A
        ex = ax; ey = ay;
      end
      4: begin // B passes through A's endpoint region
        qx = ex; qy = ey;
      end
      default: ;
    endcase
    send_pair(ax, ay, ex, ey, qx, qy, fx, fy);
  endtask

  localparam coord_t MX = {1'b0, {(CB-1){1'b1}}};
  localparam coord_t MN = {1'b1, {(CB-1){1'b0}}};

  // Sender
  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: crossing, miss, extremes, collinear touch/overlap, parallel
    send_pair(0, 0, 10, 10, 0, 10, 10, 0);
    send_pair(0, 0, 1, 1, 5, 5, 6, 7);
    send_pair(MN, MN, MX, MX, MN, MX, MX, MN);
    send_pair(MX, MN, MN, MX, MN, MN, MX, MX);
    send_pair(MN, 0, MX, 0, 0, MN, 0, MX);
    send_pair(0, 0, 5, 0, 5, 0, 9, 0);
    send_pair(2, 2, 5, 5, 0, 0, 2, 2);
    send_pair(0, 0, 5, 0, 3, 0, 9, 0);
    send_pair(0, 0, 5, 0, 0, 1, 5, 1);
    send_pair(4, 4, 4, 4, 4, 4, 4, 4);
    send_pair(4, 4, 4, 4, 0, 0, 8, 8);
    send_pair(-7, 3, 9, -2, 1, -6, -3, 8);
    send_pair(0, 0, 3, 0, 1, -1, 1, 1);
    send_pair(0, 0, -3, -1, -1, 1, -2, -3);
    send_pair(MX, MX, MX, MX, MX, MX, MN, MN);
    send_pair('1, '1, MN, MX, MX, MN, '0, '0);
    send_pair(0, 0, 10, 0, 10, 0, 10, 10);
    send_pair(0, 0, 10, 0, 11, 0, 10, 10);
    // drain pause: wait for every expected result
    valid_in <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_rx = 1;
      if (i == N_RANDOM - 150) calm = 1;
      send_random();
    end
    valid_in <= 1'b0;
    stim_done = 1;
  end

  // Receiver: random stall bursts, one long hold-off to back up the pipe
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        hold_rx = 0;
        ready_out <= 1'b0;
        repeat (3 * LATENCY + 20) @(negedge clk);
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        ready_out <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      ready_out <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d segment pairs sent, %0d results checked, %0d hits", items_sent, results,
             hits);
    $display("covered crossings, misses, collinear touches, parallels, degenerate segments");
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
